[design/uvac_pkg.sv]
package uvac_pkg;

  // component format
  localparam int FRAC_BITS = 14;
  localparam int COMP_W    = 16;

  // conversion of 2F-fraction magnitudes to 30 fraction bits
  localparam int Q30_SHIFT = 30 - 2 * FRAC_BITS;
  localparam int Q30_SHL   = (Q30_SHIFT >= 0) ? Q30_SHIFT : 0;
  localparam int Q30_SHR   = (Q30_SHIFT >= 0) ? 0 : -Q30_SHIFT;

  localparam int MAG_W     = 32;
  localparam logic [MAG_W-1:0] SAT31 = 32'h8000_0000;
  localparam logic [MAG_W-1:0] ONE30 = 32'h4000_0000;

  // square root pipeline
  localparam int SQRT_STEPS = 32;

  // angle arithmetic
  localparam int CORDIC_STEPS = 25;
  localparam int XY_W         = 36;
  localparam int Z_W          = 28;
  localparam logic signed [Z_W-1:0] PI24 = 28'sd52707179;
  localparam logic [14:0] PI13      = 15'd25736;
  localparam logic [14:0] HALF_PI13 = 15'd12868;

  localparam logic [24:0] ATAN_TABLE [CORDIC_STEPS] = '{
    25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214,
    25'd524117, 25'd262123, 25'd131069, 25'd65536, 25'd32768, 25'd16384,
    25'd8192, 25'd4096, 25'd2048, 25'd1024, 25'd512, 25'd256, 25'd128,
    25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2, 25'd1
  };

  // register map
  localparam logic REG_ANGLE_TOLERANCE = 1'b0;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
    logic signed [15:0] ref_z;
  } in_item_t;

  typedef struct packed {
    logic        [14:0] angle;
    logic signed [15:0] signed_angle;
    logic               is_equal;
    logic               is_normal;
    logic               is_opposite;
    logic               is_parallel;
  } out_item_t;

  // sideband that rides along the long stages
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             use_acos;
    logic             dot_neg;
    logic             cross_neg;
  } side_t;

  function automatic logic [MAG_W-1:0] to_q30(input logic [33:0] mag);
    logic [33:0] shifted;
    logic [MAG_W-1:0] res;
    shifted = '0;
    res = '0;
    if (Q30_SHIFT >= 0) begin
      if (mag >= (34'(SAT31) >> Q30_SHL)) begin
        res = SAT31;
      end else begin
        shifted = mag << Q30_SHL;
        res = shifted[MAG_W-1:0];
      end
    end else begin
      shifted = mag >> Q30_SHR;
      res = (shifted > 34'(SAT31)) ? SAT31 : shifted[MAG_W-1:0];
    end
    return res;
  endfunction

endpackage

[design/uvac_front.sv]
module uvac_front import uvac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        out_valid,
  output logic [63:0] out_sq,
  output side_t       out_side
);

  // stage 1: component products
  logic               s1_valid;
  logic signed [31:0] s1_pd [3];
  logic signed [31:0] s1_pc [6];
  logic signed [15:0] s1_rx, s1_ry, s1_rz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pd[0] <= in_data.first_x * in_data.second_x;
      s1_pd[1] <= in_data.first_y * in_data.second_y;
      s1_pd[2] <= in_data.first_z * in_data.second_z;
      s1_pc[0] <= in_data.first_y * in_data.second_z;
      s1_pc[1] <= in_data.first_z * in_data.second_y;
      s1_pc[2] <= in_data.first_z * in_data.second_x;
      s1_pc[3] <= in_data.first_x * in_data.second_z;
      s1_pc[4] <= in_data.first_x * in_data.second_y;
      s1_pc[5] <= in_data.first_y * in_data.second_x;
      s1_rx    <= in_data.ref_x;
      s1_ry    <= in_data.ref_y;
      s1_rz    <= in_data.ref_z;
    end
  end

  // stage 2: dot product and cross components
  logic               s2_valid;
  logic signed [33:0] s2_dot;
  logic signed [32:0] s2_c [3];
  logic signed [15:0] s2_r [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dot  <= 34'(s1_pd[0]) + 34'(s1_pd[1]) + 34'(s1_pd[2]);
      s2_c[0] <= 33'(s1_pc[0]) - 33'(s1_pc[1]);
      s2_c[1] <= 33'(s1_pc[2]) - 33'(s1_pc[3]);
      s2_c[2] <= 33'(s1_pc[4]) - 33'(s1_pc[5]);
      s2_r[0] <= s1_rx;
      s2_r[1] <= s1_ry;
      s2_r[2] <= s1_rz;
    end
  end

  // stage 3: squares, triple terms, cosine magnitude
  logic               s3_valid;
  logic signed [48:0] s3_tp [3];
  logic        [63:0] s3_sqc [3];
  logic [MAG_W-1:0]   s3_cmag;
  logic               s3_dot_neg;
  logic signed [65:0] sq_full [3];
  logic        [33:0] dot_abs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_full[k] = s2_c[k] * s2_c[k];
    end
    dot_abs = s2_dot[33] ? 34'(-s2_dot) : 34'(s2_dot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_tp[k]  <= 49'(s2_c[k] * s2_r[k]);
        s3_sqc[k] <= sq_full[k][63:0];
      end
      s3_cmag    <= to_q30(dot_abs);
      s3_dot_neg <= s2_dot[33];
    end
  end

  // stage 4: sums, branch choice
  logic signed [50:0] triple;
  logic        [63:0] cmag_sq;

  assign triple  = 51'(s3_tp[0]) + 51'(s3_tp[1]) + 51'(s3_tp[2]);
  assign cmag_sq = 64'(s3_cmag) * 64'(s3_cmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sq             <= s3_sqc[0] + s3_sqc[1] + s3_sqc[2];
      out_side.mag       <= s3_cmag;
      out_side.use_acos  <= cmag_sq < (64'd1 << 59);
      out_side.dot_neg   <= s3_dot_neg;
      out_side.cross_neg <= triple[50];
    end
  end

endmodule

[design/uvac_sqrt.sv]
module uvac_sqrt import uvac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] in_rad,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output side_t       out_side
);

  // one result bit per stage, restoring digit recurrence
  logic        valid [SQRT_STEPS+1];
  logic [63:0] rem   [SQRT_STEPS+1];
  logic [63:0] root  [SQRT_STEPS+1];
  side_t       side  [SQRT_STEPS+1];

  assign valid[0] = in_valid;
  assign rem[0]   = in_rad;
  assign root[0]  = '0;
  assign side[0]  = in_side;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        take;

    assign trial = root[i] + BIT;
    assign take  = rem[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (adv) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[i+1] <= side[i];
        if (take) begin
          rem[i+1]  <= rem[i] - trial;
          root[i+1] <= (root[i] >> 1) + BIT;
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= root[i] >> 1;
        end
      end
    end
  end

  assign out_valid = valid[SQRT_STEPS];
  assign out_root  = root[SQRT_STEPS][31:0];
  assign out_side  = side[SQRT_STEPS];

endmodule

[design/uvac_cordic.sv]
module uvac_cordic import uvac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [XY_W-1:0] in_x,
  input  logic signed [XY_W-1:0] in_y,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic signed [Z_W-1:0] out_z,
  output side_t                 out_side
);

  // vectoring rotations, one per stage
  logic                   valid [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x     [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y     [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z     [CORDIC_STEPS+1];
  side_t                  side  [CORDIC_STEPS+1];

  assign valid[0] = in_valid;
  assign x[0]     = in_x;
  assign y[0]     = in_y;
  assign z[0]     = '0;
  assign side[0]  = in_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TABLE[i]);
    logic signed [XY_W-1:0] dx, dy;

    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (adv) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[i+1] <= side[i];
        if (!y[i][XY_W-1]) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ATAN;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ATAN;
        end
      end
    end
  end

  assign out_valid = valid[CORDIC_STEPS];
  assign out_z     = z[CORDIC_STEPS];
  assign out_side  = side[CORDIC_STEPS];

endmodule

[design/unit_vector_angle_compare_top.sv]
// Angle between two direction vectors: one item (two Q2.14 directions and a
// reference) is taken every clock cycle unless the pipeline stalls; each
// result passes through the two 32-stage square-root pipelines and
// the 25-stage CORDIC, each resolving one bit or rotation per stage. The
// output register holds a result the sink has not taken while items keep
// entering; the pipeline stalls only when its last stage also holds one.
// The angle is Q3.13 in 0..pi, signed by the cross product against the
// reference; the flags compare it with angle_tolerance at APB address 0.
module unit_vector_angle_compare_top import uvac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // configuration register
  logic [14:0] tolerance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ANGLE_TOLERANCE) ? {17'd0, tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ANGLE_TOLERANCE) begin
      tolerance <= pwdata[14:0];
    end
  end

  // global advance: stall only when the last stage and the output are both full
  logic adv;
  logic last_valid;

  assign adv      = !last_valid || !out_valid || out_ready;
  assign in_ready = adv;

  // products, sums, squared sine
  logic        f_valid;
  logic [63:0] f_sq;
  side_t       f_side;

  uvac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid && in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_sq    (f_sq),
    .out_side  (f_side)
  );

  // sine magnitude
  logic        s1_valid;
  logic [31:0] s1_root;
  side_t       s1_side;

  uvac_sqrt u_sqrt_sin (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_rad    (f_sq),
    .in_side   (f_side),
    .out_valid (s1_valid),
    .out_root  (s1_root),
    .out_side  (s1_side)
  );

  // pick the leg that feeds the complement root
  logic [MAG_W-1:0] smag, sclamp;
  logic             m1_valid;
  side_t            m1_side;

  assign smag   = to_q30({2'b00, s1_root});
  assign sclamp = (smag > ONE30) ? ONE30 : smag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side.mag       <= s1_side.use_acos ? s1_side.mag : sclamp;
      m1_side.use_acos  <= s1_side.use_acos;
      m1_side.dot_neg   <= s1_side.dot_neg;
      m1_side.cross_neg <= s1_side.cross_neg;
    end
  end

  // one minus the square of that leg
  logic        m2_valid;
  logic [63:0] m2_rad;
  side_t       m2_side;
  logic [63:0] leg_sq;

  assign leg_sq = 64'(m1_side.mag) * 64'(m1_side.mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_rad  <= (64'd1 << 60) - leg_sq;
      m2_side <= m1_side;
    end
  end

  logic        s2_valid;
  logic [31:0] s2_root;
  side_t       s2_side;

  uvac_sqrt u_sqrt_comp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m2_valid),
    .in_rad    (m2_rad),
    .in_side   (m2_side),
    .out_valid (s2_valid),
    .out_root  (s2_root),
    .out_side  (s2_side)
  );

  // atan2 of the two legs
  logic signed [XY_W-1:0] cx, cy;
  logic                   c_valid;
  logic signed [Z_W-1:0]  c_z;
  side_t                  c_side;

  assign cx = s2_side.use_acos ? XY_W'(s2_side.mag) : XY_W'(s2_root);
  assign cy = s2_side.use_acos ? XY_W'(s2_root) : XY_W'(s2_side.mag);

  uvac_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s2_valid),
    .in_x      (cx),
    .in_y      (cy),
    .in_side   (s2_side),
    .out_valid (c_valid),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  // fold into 0..pi and round to Q3.13
  logic signed [Z_W-1:0] a24, a24_clamp;
  logic        [Z_W-1:0] a_round;
  logic        [14:0]    a13_raw;
  logic        [14:0]    a13;
  logic                  a_cross_neg;

  always_comb begin
    a24 = c_side.dot_neg ? (PI24 - c_z) : c_z;
    if (a24 < 0) begin
      a24_clamp = '0;
    end else if (a24 > PI24) begin
      a24_clamp = PI24;
    end else begin
      a24_clamp = a24;
    end
    a_round = (Z_W'(a24_clamp) + Z_W'(1024)) >> 11;
    a13_raw = (a_round > Z_W'(PI13)) ? PI13 : a_round[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (adv) begin
      last_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a13         <= a13_raw;
      a_cross_neg <= c_side.cross_neg;
    end
  end

  // flags and output register
  logic [14:0] dn;
  logic        eq_flag, opp_flag;

  assign dn       = (a13 > HALF_PI13) ? (a13 - HALF_PI13) : (HALF_PI13 - a13);
  assign eq_flag  = a13 <= tolerance;
  assign opp_flag = (PI13 - a13) <= tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last_valid || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_valid) begin
      out_data.angle        <= a13;
      out_data.signed_angle <= a_cross_neg ? -$signed({1'b0, a13}) : $signed({1'b0, a13});
      out_data.is_equal     <= eq_flag;
      out_data.is_normal    <= dn <= tolerance;
      out_data.is_opposite  <= opp_flag;
      out_data.is_parallel  <= eq_flag || opp_flag;
    end
  end

  // checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.angle <= PI13) else $error("angle above pi");

  a_parallel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_parallel == (out_data.is_equal || out_data.is_opposite))
    else $error("parallel flag mismatch");

  a_sign_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.signed_angle == $signed({1'b0, out_data.angle}) ||
                   out_data.signed_angle == -$signed({1'b0, out_data.angle})))
    else $error("signed angle magnitude mismatch");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import uvac_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  unit_vector_angle_compare_top i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam int LATENCY = 97;
  localparam int RAND_ITEMS = 1600;
  localparam logic [2:0] ADDR_TOL = 3'(4 * REG_ANGLE_TOLERANCE);

  // directed row: components plus optional typed-in result
  typedef struct {
    logic signed [15:0] c [9];
    bit                 known;
    logic [14:0]        angle;
  } row_t;

  out_item_t   angle_queue[$];
  logic [14:0] tol_setting;
  int          errors;
  bit          sink_hold;
  bit          long_hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #400ms;
    $display("FAILED: results differ");
    $finish;
  end

  // floor shift for negative values
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // 2F fraction magnitude to 30 fraction bits, saturated at 2^31
  function automatic longint unsigned mag_q30(longint unsigned m);
    int e;
    e = 30 - 2 * FRAC_BITS;
    if (e >= 0) begin
      if (m >= (64'd1 << (31 - e))) return 64'd1 << 31;
      return m << e;
    end
    m >>= -e;
    return (m > (64'd1 << 31)) ? (64'd1 << 31) : m;
  endfunction

  // vectoring cordic, first quadrant, 24 fraction bits
  function automatic longint cordic_atan(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
      end
    end
    return z;
  endfunction

  function automatic out_item_t predict_angle(in_item_t d, logic [14:0] tol);
    longint ax, ay, az, bx, by, bz, dot, cx, cy, cz, triple, theta, a24;
    longint unsigned sq, cmag, smag, s, a13, dn, one60;
    out_item_t r;
    ax = d.first_x; ay = d.first_y; az = d.first_z;
    bx = d.second_x; by = d.second_y; bz = d.second_z;
    dot = ax * bx + ay * by + az * bz;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    triple = cx * longint'(d.ref_x) + cy * longint'(d.ref_y) + cz * longint'(d.ref_z);
    sq = cx * cx + cy * cy + cz * cz;
    cmag = mag_q30(dot < 0 ? -dot : dot);
    smag = mag_q30(int_sqrt(sq));
    one60 = 64'd1 << 60;
    if (2 * cmag * cmag < one60) begin
      theta = cordic_atan(longint'(cmag), int_sqrt(one60 - cmag * cmag));
    end else begin
      s = (smag > (64'd1 << 30)) ? (64'd1 << 30) : smag;
      theta = cordic_atan(int_sqrt(one60 - s * s), longint'(s));
    end
    a24 = (dot < 0) ? longint'(PI24) - theta : theta;
    if (a24 < 0) a24 = 0;
    if (a24 > longint'(PI24)) a24 = longint'(PI24);
    a13 = (longint'(a24) + 1024) >> 11;
    if (a13 > PI13) a13 = PI13;
    dn = (a13 > HALF_PI13) ? a13 - HALF_PI13 : HALF_PI13 - a13;
    r.angle        = a13[14:0];
    r.signed_angle = (triple >= 0) ? 16'(a13) : 16'(-longint'(a13));
    r.is_equal     = a13 <= tol;
    r.is_normal    = dn <= tol;
    r.is_opposite  = (PI13 - a13) <= tol;
    r.is_parallel  = r.is_equal | r.is_opposite;
    return r;
  endfunction

  // mostly short gaps, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic tol_write(logic [14:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_TOL;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_setting = v;
  endtask

  task automatic wait_drained();
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_item(in_item_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_queue.push_back(predict_angle(d, tol_setting));
  endtask

  task automatic send_gap(in_item_t d, bit idle);
    int g;
    send_item(d);
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom());
    if (p == 1) return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // mostly roughly unit vectors (random directions scaled), some raw or per-component random
  function automatic in_item_t rand_item();
    in_item_t d;
    real v [9];
    real n;
    int p;
    p = $urandom_range(0, 9);
    if (p < 2) begin
      d = in_item_t'(144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
      return d;
    end
    if (p < 4) begin
      d.first_x = rand_comp(); d.first_y = rand_comp(); d.first_z = rand_comp();
      d.second_x = rand_comp(); d.second_y = rand_comp(); d.second_z = rand_comp();
      d.ref_x = rand_comp(); d.ref_y = rand_comp(); d.ref_z = rand_comp();
      return d;
    end
    for (int k = 0; k < 9; k++) v[k] = real'($urandom_range(0, 2000)) - 1000.0;
    // pull the second vector close to (or opposite) the first now and then
    if (p == 8) for (int k = 3; k < 6; k++) v[k] = v[k-3] + real'($urandom_range(0, 20)) - 10.0;
    if (p == 9) for (int k = 3; k < 6; k++) v[k] = -v[k-3] + real'($urandom_range(0, 20)) - 10.0;
    for (int j = 0; j < 9; j += 3) begin
      n = $sqrt(v[j] * v[j] + v[j+1] * v[j+1] + v[j+2] * v[j+2]);
      if (n < 1.0) n = 1.0;
      for (int k = j; k < j + 3; k++) v[k] = v[k] / n * 16384.0;
    end
    d.first_x = 16'($rtoi(v[0])); d.first_y = 16'($rtoi(v[1])); d.first_z = 16'($rtoi(v[2]));
    d.second_x = 16'($rtoi(v[3])); d.second_y = 16'($rtoi(v[4]));
    d.second_z = 16'($rtoi(v[5]));
    d.ref_x = 16'($rtoi(v[6])); d.ref_y = 16'($rtoi(v[7])); d.ref_z = 16'($rtoi(v[8]));
    return d;
  endfunction

  function automatic in_item_t row_item(row_t r);
    in_item_t d;
    d = {r.c[0], r.c[1], r.c[2], r.c[3], r.c[4], r.c[5], r.c[6], r.c[7], r.c[8]};
    return d;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        $error("unexpected item: angle %0d", out_data.angle);
        errors++;
      end else begin
        exp_r = angle_queue.pop_front();
        if (out_data.angle !== exp_r.angle) begin
          $error("angle: expected %0d, got %0d", exp_r.angle, out_data.angle);
          errors++;
        end
        if (out_data.signed_angle !== exp_r.signed_angle) begin
          $error("signed_angle: expected %0d, got %0d", exp_r.signed_angle,
                 out_data.signed_angle);
          errors++;
        end
        if (out_data.is_equal !== exp_r.is_equal) begin
          $error("is_equal: expected %0b, got %0b", exp_r.is_equal, out_data.is_equal);
          errors++;
        end
        if (out_data.is_normal !== exp_r.is_normal) begin
          $error("is_normal: expected %0b, got %0b", exp_r.is_normal, out_data.is_normal);
          errors++;
        end
        if (out_data.is_opposite !== exp_r.is_opposite) begin
          $error("is_opposite: expected %0b, got %0b", exp_r.is_opposite,
                 out_data.is_opposite);
          errors++;
        end
        if (out_data.is_parallel !== exp_r.is_parallel) begin
          $error("is_parallel: expected %0b, got %0b", exp_r.is_parallel,
                 out_data.is_parallel);
          errors++;
        end
      end
    end
  end

  // sink with random stalls and one long hold-off on request
  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (sink_hold) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    row_t r;
    logic [14:0] tol_list [5];
    in_item_t d;
    errors = 0;
    sink_hold = 1'b0;
    long_hold_req = 1'b0;
    tol_setting = '0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: same, opposite, normal, zero, extremes
    r.known = 1'b1;
    r.c = '{16384, 0, 0, 16384, 0, 0, 0, 0, 16384}; r.angle = 0; rows.push_back(r);
    r.c = '{16384, 0, 0, -16384, 0, 0, 0, 0, 16384}; r.angle = PI13; rows.push_back(r);
    r.c = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; r.angle = HALF_PI13; rows.push_back(r);
    r.c = '{16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; r.angle = HALF_PI13; rows.push_back(r);
    r.c = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; r.angle = HALF_PI13; rows.push_back(r);
    r.c = '{0, 0, 16384, 0, 0, 0, 1, 1, 1}; r.angle = HALF_PI13; rows.push_back(r);
    r.known = 1'b0;
    r.c = '{32767, 32767, 32767, 32767, -32768, 32767, 0, 0, 0}; rows.push_back(r);
    r.c = '{-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 1}; rows.push_back(r);
    r.c = '{-32768, 32767, -32768, 32767, -32768, 32767, -1, -1, -1}; rows.push_back(r);
    r.c = '{16384, 16384, 0, 16384, 0, 0, 0, 0, 16384}; rows.push_back(r);
    r.c = '{11585, 11585, 0, 16384, 0, 0, 0, 0, -16384}; rows.push_back(r);
    r.c = '{11585, 11585, 0, -16384, 0, 0, 0, 0, 16384}; rows.push_back(r);
    r.c = '{16384, 0, 0, 16383, 181, 0, 0, 0, 16384}; rows.push_back(r);
    r.c = '{16384, 0, 0, -16383, 181, 0, 0, 0, 16384}; rows.push_back(r);
    r.c = '{9459, 9459, 9459, 9459, -9459, 9459, 16384, 0, 0}; rows.push_back(r);
    r.c = '{16384, 0, 0, 8192, 14189, 0, 0, 0, -16384}; rows.push_back(r);

    foreach (rows[i]) begin
      d = row_item(rows[i]);
      send_item(d);
      if (rows[i].known && angle_queue[$].angle !== rows[i].angle) begin
        $error("angle: table %0d, predictor %0d", rows[i].angle, angle_queue[$].angle);
        errors++;
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    // random phases over tolerance settings, extremes included
    tol_list = '{15'd0, 15'd25736, 15'd32767, 15'd12868, 15'd40};
    sink_hold = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      tol_write(ph == 4 ? 15'($urandom_range(1, 400)) : tol_list[ph]);
      if (ph == 1) long_hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 5; n++) begin
        d = rand_item();
        // one stretch with no idling per phase
        send_gap(d, (n < 60) ? 1'b0 : 1'b1);
        if (n == RAND_ITEMS / 10) begin
          in_valid <= 1'b0;
          while (angle_queue.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
